[sv/ole_pkg.sv]
`timescale 1ns / 1ps

package ole_pkg;

  // Sizing of the list and of the word fields.
  localparam int CAPACITY    = 16;
  localparam int VALUE_W     = 32;
  localparam int MODE_W      = 3;
  localparam int POS_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request modes carried by an input word.
  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_DEL_HEAD  = 3'd1,
    MODE_DEL_TAIL  = 3'd2,
    MODE_DEL_POS   = 3'd3,
    MODE_DEL_VALUE = 3'd4,
    MODE_LIST      = 3'd5
  } mode_t;

  // Status codes carried by an output word.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_SCAN,
    S_LIST,
    S_EMIT
  } state_t;

  // One access to the entry store: an optional write and a read address.
  typedef struct packed {
    logic                      we;
    logic [IDX_W-1:0]          waddr;
    logic signed [VALUE_W-1:0] wdata;
    logic [IDX_W-1:0]          raddr;
  } mem_req_t;

endpackage

[sv/ole_store.sv]
`timescale 1ns / 1ps

module ole_store (
  input  logic                               clk,
  input  ole_pkg::mem_req_t                  req,
  output logic signed [ole_pkg::VALUE_W-1:0] rdata
);

  logic signed [ole_pkg::VALUE_W-1:0] entries [ole_pkg::CAPACITY];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      entries[req.waddr] <= req.wdata;
    end
    rdata <= entries[req.raddr];
  end

endmodule

[sv/ordered_list_engine.sv]
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// ------    ---------------------   ------------------------------------
// input     in_valid / in_stall     mode, value, position
// output    out_valid / out_stall   status, item_value, count, last
//
// A request's word is taken and then decoded in S_EXEC; a removal, a search or a
// listing then walks the entry store at one entry per cycle, a listing only while
// the output is not stalled; the single store read port and the one comparator set that rate.
// A listing gives one output word per entry, each held until it is taken.
// in_stall is high from acceptance until the last output word is loaded.
// Synchronous reset empties the list; stored values are not cleared.

module ordered_list_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [ole_pkg::MODE_W-1:0]             mode,
  input  logic signed [ole_pkg::VALUE_W-1:0]     value,
  input  logic [ole_pkg::POS_W-1:0]              position,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ole_pkg::STATUS_W-1:0]           status,
  output logic signed [ole_pkg::VALUE_W-1:0]     item_value,
  output logic [ole_pkg::COUNT_OUT_W-1:0]        count,
  output logic                                   last
);

  localparam int CNT_W = ole_pkg::CNT_W;
  localparam int IDX_W = ole_pkg::IDX_W;
  localparam int CMP_W = ole_pkg::CMP_W;

  ole_pkg::state_t                    state, state_next;
  ole_pkg::mode_t                     req_mode;
  logic signed [ole_pkg::VALUE_W-1:0] req_value;
  logic [ole_pkg::POS_W-1:0]          req_position;
  logic [IDX_W-1:0]                   ptr, ptr_next;
  logic [CNT_W-1:0]                   entry_count, entry_count_next;
  ole_pkg::status_t                   pend, pend_next;
  ole_pkg::mem_req_t                  mem_req;
  logic signed [ole_pkg::VALUE_W-1:0] rdata;

  logic                               in_take;
  logic                               out_free;
  logic                               load;
  ole_pkg::status_t                   load_status;
  logic signed [ole_pkg::VALUE_W-1:0] load_item;
  logic                               load_last;

  logic                               is_empty;
  logic                               is_full;
  logic                               pos_ok;
  logic                               rm_ok;
  logic [IDX_W-1:0]                   rm_idx;
  logic                               rm_more;
  logic [CNT_W-1:0]                   ptr_c1;
  logic [CNT_W-1:0]                   ptr_c2;
  logic                               scan_more;
  logic                               hit;
  logic [CNT_W+ole_pkg::COUNT_OUT_W-1:0] count_wide;

  ole_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign in_stall = (state != ole_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Shared conditions of the sequencer.
  assign is_empty  = (entry_count == '0);
  assign is_full   = (entry_count == CNT_W'(ole_pkg::CAPACITY));
  assign pos_ok    = (req_position != '0) &&
                     (CMP_W'(req_position) <= CMP_W'(entry_count));
  assign rm_ok     = (req_mode == ole_pkg::MODE_DEL_HEAD) || pos_ok;
  assign rm_idx    = (req_mode == ole_pkg::MODE_DEL_HEAD) ? '0 :
                     IDX_W'(req_position - ole_pkg::POS_W'(1));
  assign rm_more   = ((CNT_W'(rm_idx) + CNT_W'(1)) < entry_count);
  assign ptr_c1    = CNT_W'(ptr) + CNT_W'(1);
  assign ptr_c2    = CNT_W'(ptr) + CNT_W'(2);
  assign scan_more = (ptr_c1 < entry_count);
  assign hit       = (rdata == req_value);

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_mode     <= ole_pkg::mode_t'(mode);
      req_value    <= value;
      req_position <= position;
    end
  end

  // Sequencer and list registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ole_pkg::S_IDLE;
      entry_count <= '0;
      ptr         <= '0;
      pend        <= ole_pkg::ST_OK;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      ptr         <= ptr_next;
      pend        <= pend_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ole_pkg::S_IDLE: begin
        if (in_take) state_next = ole_pkg::S_EXEC;
      end
      ole_pkg::S_EXEC: begin
        case (req_mode)
          ole_pkg::MODE_DEL_HEAD, ole_pkg::MODE_DEL_POS: begin
            if (!is_empty && rm_ok && rm_more) state_next = ole_pkg::S_SHIFT;
            else                               state_next = ole_pkg::S_EMIT;
          end
          ole_pkg::MODE_DEL_VALUE: begin
            state_next = is_empty ? ole_pkg::S_EMIT : ole_pkg::S_SCAN;
          end
          ole_pkg::MODE_LIST: begin
            state_next = is_empty ? ole_pkg::S_EMIT : ole_pkg::S_LIST;
          end
          default: state_next = ole_pkg::S_EMIT;
        endcase
      end
      ole_pkg::S_SCAN: begin
        if (hit) state_next = scan_more ? ole_pkg::S_SHIFT : ole_pkg::S_EMIT;
        else if (!scan_more) state_next = ole_pkg::S_EMIT;
      end
      ole_pkg::S_SHIFT: begin
        if (ptr_c2 >= entry_count) state_next = ole_pkg::S_EMIT;
      end
      ole_pkg::S_LIST: begin
        if (out_free && !scan_more) state_next = ole_pkg::S_IDLE;
      end
      ole_pkg::S_EMIT: begin
        if (out_free) state_next = ole_pkg::S_IDLE;
      end
      default: state_next = ole_pkg::S_IDLE;
    endcase
  end

  // Datapath control: store access, pointer, count and output loading.
  always_comb begin
    ptr_next         = ptr;
    entry_count_next = entry_count;
    pend_next        = pend;
    mem_req.we       = 1'b0;
    mem_req.waddr    = ptr;
    mem_req.wdata    = rdata;
    mem_req.raddr    = ptr;
    load             = 1'b0;
    load_status      = pend;
    load_item        = '0;
    load_last        = 1'b1;
    unique case (state)
      ole_pkg::S_EXEC: begin
        pend_next = ole_pkg::ST_OK;
        case (req_mode)
          ole_pkg::MODE_APPEND: begin
            if (is_full) begin
              pend_next = ole_pkg::ST_FULL;
            end else begin
              mem_req.we       = 1'b1;
              mem_req.waddr    = IDX_W'(entry_count);
              mem_req.wdata    = req_value;
              entry_count_next = entry_count + CNT_W'(1);
            end
          end
          ole_pkg::MODE_DEL_HEAD, ole_pkg::MODE_DEL_POS: begin
            if (is_empty) begin
              pend_next = ole_pkg::ST_EMPTY;
            end else if (!rm_ok) begin
              pend_next = ole_pkg::ST_NOTFOUND;
            end else begin
              ptr_next      = rm_idx;
              mem_req.raddr = IDX_W'(CNT_W'(rm_idx) + CNT_W'(1));
              if (!rm_more) entry_count_next = entry_count - CNT_W'(1);
            end
          end
          ole_pkg::MODE_DEL_TAIL: begin
            if (is_empty) pend_next = ole_pkg::ST_EMPTY;
            else          entry_count_next = entry_count - CNT_W'(1);
          end
          ole_pkg::MODE_DEL_VALUE, ole_pkg::MODE_LIST: begin
            ptr_next      = '0;
            mem_req.raddr = '0;
            if (is_empty) pend_next = ole_pkg::ST_EMPTY;
          end
          default: ;
        endcase
      end
      ole_pkg::S_SCAN: begin
        // Compare the entry read last cycle; on a match the shift starts there.
        mem_req.raddr = IDX_W'(ptr_c1);
        if (hit) begin
          pend_next = ole_pkg::ST_OK;
          if (!scan_more) entry_count_next = entry_count - CNT_W'(1);
        end else if (scan_more) begin
          ptr_next = IDX_W'(ptr_c1);
        end else begin
          pend_next = ole_pkg::ST_NOTFOUND;
        end
      end
      ole_pkg::S_SHIFT: begin
        // Move the following entry down one place and read the next one.
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr;
        mem_req.wdata = rdata;
        mem_req.raddr = IDX_W'(ptr_c2);
        ptr_next      = IDX_W'(ptr_c1);
        if (ptr_c2 >= entry_count) entry_count_next = entry_count - CNT_W'(1);
      end
      ole_pkg::S_LIST: begin
        // Hold the read address while the output is full, so the data stays.
        load_status = ole_pkg::ST_OK;
        load_item   = rdata;
        load_last   = !scan_more;
        if (out_free) begin
          load = 1'b1;
          if (scan_more) begin
            ptr_next      = IDX_W'(ptr_c1);
            mem_req.raddr = IDX_W'(ptr_c1);
          end
        end
      end
      ole_pkg::S_EMIT: begin
        load = out_free;
      end
      default: ;
    endcase
  end

  // Output register.
  assign count_wide = {{ole_pkg::COUNT_OUT_W{1'b0}}, entry_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status     <= load_status;
      item_value <= load_item;
      count      <= count_wide[ole_pkg::COUNT_OUT_W-1:0];
      last       <= load_last;
    end
  end

  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(ole_pkg::CAPACITY))
    else $error("entry count above capacity");

  // The count moves by exactly one, and only while a mutating request runs.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (entry_count != $past(entry_count)) |->
      ((entry_count == $past(entry_count) + CNT_W'(1)) ||
       (entry_count == $past(entry_count) - CNT_W'(1))) &&
      (($past(state) == ole_pkg::S_EXEC) || ($past(state) == ole_pkg::S_SCAN) ||
       ($past(state) == ole_pkg::S_SHIFT)))
    else $error("entry count changed outside a removal or append");

  // A word that is not the last of its request only comes from a listing in progress.
  a_more_in_list: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (state == ole_pkg::S_LIST))
    else $error("non-final word outside a listing");

endmodule
